// ===== src/easc_pkg.sv =====
// Package of shared constants, word types and codes for the edge-adaptive sample count unit.
package easc_pkg;

   localparam int MAX_WIDTH      = 1024;
   localparam int MAX_HEIGHT     = 1024;
   localparam int CHANNEL_BITS   = 8;
   localparam int PIXEL_BITS     = 3 * CHANNEL_BITS;
   localparam int LINE_BITS      = 2 * PIXEL_BITS;
   localparam int GRAD_BITS      = CHANNEL_BITS + 3;
   localparam int COL_BITS       = $clog2(MAX_WIDTH);
   localparam int ROW_BITS       = $clog2(MAX_HEIGHT);
   localparam int CFG_BITS       = 11;
   localparam int POS_FIELD_BITS = 10;
   localparam int COUNT_BITS     = 5;
   localparam int CSR_ADDR_BITS  = 5;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [COUNT_BITS-1:0] COUNT_ONE          = 5'd1;
   localparam logic [COUNT_BITS-1:0] COUNT_FOUR         = 5'd4;
   localparam logic [COUNT_BITS-1:0] COUNT_NINE         = 5'd9;
   localparam logic [COUNT_BITS-1:0] COUNT_SIXTEEN      = 5'd16;
   localparam logic [COUNT_BITS-1:0] COUNT_TWENTY_FIVE  = 5'd25;

   typedef enum logic [2:0] {
      REG_FRAME_WIDTH    = 3'd0,
      REG_FRAME_HEIGHT   = 3'd1,
      REG_EDGE_THRESHOLD = 3'd2,
      REG_LEVEL_QUARTER  = 3'd3,
      REG_LEVEL_ONE      = 3'd4,
      REG_LEVEL_TWO      = 3'd5,
      REG_LEVEL_THREE    = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic                    start_of_frame;
      logic [CHANNEL_BITS-1:0] red;
      logic [CHANNEL_BITS-1:0] green;
      logic [CHANNEL_BITS-1:0] blue;
   } req_word_type;

   typedef struct packed {
      logic                      center_valid;
      logic [POS_FIELD_BITS-1:0] center_row;
      logic [POS_FIELD_BITS-1:0] center_col;
      logic                      edge_found;
      logic [GRAD_BITS-1:0]      max_gradient;
      logic [COUNT_BITS-1:0]     sample_count;
   } rsp_word_type;

endpackage

// ===== src/edge_adaptive_sample_count_unit.sv =====
// Top level of the edge-adaptive sample count unit: line memory, 3x3 window and Sobel pipeline.
//
// Pipeline: a result word passes the memory read registers, the gradient registers and then
// the output register after the edge that accepts its pixel word, held back while the result
// side stalls. Throughput: one pixel word per cycle while the result side does not stall; the
// single-port-read line memory is read once per word.
// Reset: synchronous and active high; registers return to their documented values, counters
// and the window clear, and the line memory is left as it is (in a well-formed frame, stale
// contents only feed border results).
module edge_adaptive_sample_count_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  easc_pkg::req_word_type               req_word,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output easc_pkg::rsp_word_type               rsp_word,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [easc_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [easc_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [easc_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                 csr_pready
);

   // Width used when comparing column positions against the configured frame width.
   localparam int CMP_BITS = (easc_pkg::COL_BITS + 1 > easc_pkg::CFG_BITS) ?
                             easc_pkg::COL_BITS + 1 : easc_pkg::CFG_BITS;
   localparam int CB = easc_pkg::CHANNEL_BITS;

   // ---------------------------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------------------------
   logic [easc_pkg::CFG_BITS-1:0] frame_width_ff, frame_height_ff, edge_threshold_ff;
   logic [easc_pkg::CFG_BITS-1:0] level_quarter_ff, level_one_ff, level_two_ff;
   logic [easc_pkg::CFG_BITS-1:0] level_three_ff;
   logic                          csr_write;
   easc_pkg::reg_index_type       csr_index;
   logic [easc_pkg::CFG_BITS-1:0] csr_value;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = easc_pkg::reg_index_type'(csr_paddr[4:2]);
   assign csr_value  = csr_pwdata[easc_pkg::CFG_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff    <= 11'd600;
         frame_height_ff   <= 11'd600;
         edge_threshold_ff <= 11'd127;
         level_quarter_ff  <= 11'd127;
         level_one_ff      <= 11'd255;
         level_two_ff      <= 11'd510;
         level_three_ff    <= 11'd765;
      end else if (csr_write) begin
         case (csr_index)
            easc_pkg::REG_FRAME_WIDTH:    frame_width_ff    <= csr_value;
            easc_pkg::REG_FRAME_HEIGHT:   frame_height_ff   <= csr_value;
            easc_pkg::REG_EDGE_THRESHOLD: edge_threshold_ff <= csr_value;
            easc_pkg::REG_LEVEL_QUARTER:  level_quarter_ff  <= csr_value;
            easc_pkg::REG_LEVEL_ONE:      level_one_ff      <= csr_value;
            easc_pkg::REG_LEVEL_TWO:      level_two_ff      <= csr_value;
            easc_pkg::REG_LEVEL_THREE:    level_three_ff    <= csr_value;
            default: ;
         endcase
      end
   end

   // Reads return the register zero-extended; the unused address reads as zero.
   always_comb begin
      csr_prdata = '0;
      case (csr_index)
         easc_pkg::REG_FRAME_WIDTH:    csr_prdata = 32'(frame_width_ff);
         easc_pkg::REG_FRAME_HEIGHT:   csr_prdata = 32'(frame_height_ff);
         easc_pkg::REG_EDGE_THRESHOLD: csr_prdata = 32'(edge_threshold_ff);
         easc_pkg::REG_LEVEL_QUARTER:  csr_prdata = 32'(level_quarter_ff);
         easc_pkg::REG_LEVEL_ONE:      csr_prdata = 32'(level_one_ff);
         easc_pkg::REG_LEVEL_TWO:      csr_prdata = 32'(level_two_ff);
         easc_pkg::REG_LEVEL_THREE:    csr_prdata = 32'(level_three_ff);
         default:                      csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------------------------
   // Pipeline handshake. Each stage loads when it is empty or its word moves on this cycle,
   // so a word can enter every cycle while the output register holds a result, if it is taken.
   // ---------------------------------------------------------------------------------------
   logic s1_valid_ff, s2_valid_ff, rsp_valid_ff;
   logic out_ready, s2_free, s1_adv, req_acc;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign s2_free   = !s2_valid_ff || out_ready;
   assign s1_adv    = s1_valid_ff && s2_free;
   assign req_stall = reset || (s1_valid_ff && !s2_free);
   assign req_acc   = req_valid && !req_stall;

   // ---------------------------------------------------------------------------------------
   // Position counters. The frame size is clamped to its legal range, a start-of-frame word
   // forces position (0,0), and a position beyond a shrunken frame folds back to zero.
   // ---------------------------------------------------------------------------------------
   logic [easc_pkg::COL_BITS-1:0] col_ff, col_in, base_c, cur_c;
   logic [easc_pkg::ROW_BITS-1:0] row_ff, row_in, base_r, cur_r;
   logic [CMP_BITS-1:0]           w_eff, fw_ext, col_next_wide;
   logic [easc_pkg::CFG_BITS-1:0] h_eff;
   logic [easc_pkg::ROW_BITS:0]   row_next_wide;

   always_comb begin
      fw_ext = CMP_BITS'(frame_width_ff);
      if (fw_ext < CMP_BITS'(3)) begin
         w_eff = CMP_BITS'(3);
      end else if (fw_ext > CMP_BITS'(easc_pkg::MAX_WIDTH)) begin
         w_eff = CMP_BITS'(easc_pkg::MAX_WIDTH);
      end else begin
         w_eff = fw_ext;
      end
      if (frame_height_ff < 11'd3) begin
         h_eff = 11'd3;
      end else if (frame_height_ff > 11'(easc_pkg::MAX_HEIGHT)) begin
         h_eff = 11'(easc_pkg::MAX_HEIGHT);
      end else begin
         h_eff = frame_height_ff;
      end

      base_c = req_word.start_of_frame ? '0 : col_ff;
      base_r = req_word.start_of_frame ? '0 : row_ff;
      cur_c  = (CMP_BITS'(base_c) >= w_eff) ? '0 : base_c;
      cur_r  = (11'(base_r) >= h_eff) ? '0 : base_r;

      col_next_wide = CMP_BITS'(cur_c) + CMP_BITS'(1);
      row_next_wide = {1'b0, cur_r} + 1'b1;
      col_in = cur_c + easc_pkg::COL_BITS'(1);
      row_in = cur_r;
      if (col_next_wide >= w_eff) begin
         col_in = '0;
         row_in = (11'(row_next_wide) >= h_eff) ? '0 : row_next_wide[easc_pkg::ROW_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_acc) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stage 1: the line memory. Each entry holds the pixel two rows up (upper half) and one
   // row up (lower half) for its column. The read is issued as the word is accepted; the
   // write-back of {middle, new pixel} happens as the word leaves stage 1. When the word
   // being accepted reads the column written on the same edge, the written data is
   // forwarded instead of the stale memory output.
   // ---------------------------------------------------------------------------------------
   logic [easc_pkg::LINE_BITS-1:0]      line_mem [easc_pkg::MAX_WIDTH];
   logic [easc_pkg::LINE_BITS-1:0]      mem_rd_ff, fwd_data_ff, line_word, wr_data;
   logic                                fwd_valid_ff;
   logic [easc_pkg::PIXEL_BITS-1:0]     s1_px_ff, top_px, mid_px, px_in;
   logic [easc_pkg::COL_BITS-1:0]       s1_addr_ff;
   logic                                s1_center_ff;
   logic [easc_pkg::POS_FIELD_BITS-1:0] s1_row_ff, s1_col_ff;
   logic [easc_pkg::PIXEL_BITS-1:0]     window_ff [6];

   assign px_in     = {req_word.red, req_word.green, req_word.blue};
   assign line_word = fwd_valid_ff ? fwd_data_ff : mem_rd_ff;
   assign top_px    = line_word[easc_pkg::LINE_BITS-1:easc_pkg::PIXEL_BITS];
   assign mid_px    = line_word[easc_pkg::PIXEL_BITS-1:0];
   assign wr_data   = {mid_px, s1_px_ff};

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         line_mem[s1_addr_ff] <= wr_data;
      end
      if (req_acc) begin
         mem_rd_ff <= line_mem[cur_c];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else begin
         if (req_acc) begin
            s1_valid_ff  <= 1'b1;
            fwd_valid_ff <= s1_adv && (cur_c == s1_addr_ff);
         end else if (s1_adv) begin
            s1_valid_ff  <= 1'b0;
            fwd_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_px_ff     <= px_in;
         s1_addr_ff   <= cur_c;
         s1_center_ff <= (cur_r >= easc_pkg::ROW_BITS'(2)) && (cur_c >= easc_pkg::COL_BITS'(2));
         s1_row_ff    <= easc_pkg::POS_FIELD_BITS'(cur_r - easc_pkg::ROW_BITS'(1));
         s1_col_ff    <= easc_pkg::POS_FIELD_BITS'(cur_c - easc_pkg::COL_BITS'(1));
         fwd_data_ff  <= wr_data;
      end
   end

   // The window keeps the two previous columns; slot = column * 3 + row, top row first.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            window_ff[i] <= '0;
         end
      end else if (s1_adv) begin
         window_ff[0] <= window_ff[3];
         window_ff[1] <= window_ff[4];
         window_ff[2] <= window_ff[5];
         window_ff[3] <= top_px;
         window_ff[4] <= mid_px;
         window_ff[5] <= s1_px_ff;
      end
   end

   // Sobel magnitude |Gx| + |Gy| of one channel.
   function automatic logic [easc_pkg::GRAD_BITS-1:0] sobel_mag(
      input logic [CB-1:0] t0, input logic [CB-1:0] t1, input logic [CB-1:0] t2,
      input logic [CB-1:0] m0, input logic [CB-1:0] m2,
      input logic [CB-1:0] b0, input logic [CB-1:0] b1, input logic [CB-1:0] b2);
      logic [CB+1:0]        s_top, s_bot, s_right, s_left;
      logic signed [CB+2:0] dy, dx;
      logic [CB+1:0]        ay, ax;
      s_top   = {2'b00, t0} + {1'b0, t1, 1'b0} + {2'b00, t2};
      s_bot   = {2'b00, b0} + {1'b0, b1, 1'b0} + {2'b00, b2};
      s_right = {2'b00, t2} + {1'b0, m2, 1'b0} + {2'b00, b2};
      s_left  = {2'b00, t0} + {1'b0, m0, 1'b0} + {2'b00, b0};
      dy = $signed({1'b0, s_top}) - $signed({1'b0, s_bot});
      dx = $signed({1'b0, s_right}) - $signed({1'b0, s_left});
      ay = dy[CB+2] ? (CB+2)'(-dy) : (CB+2)'(dy);
      ax = dx[CB+2] ? (CB+2)'(-dx) : (CB+2)'(dx);
      return {1'b0, ay} + {1'b0, ax};
   endfunction

   logic [easc_pkg::GRAD_BITS-1:0] grad_in [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         grad_in[k] = sobel_mag(window_ff[0][k*CB +: CB], window_ff[3][k*CB +: CB],
                                top_px[k*CB +: CB], window_ff[1][k*CB +: CB],
                                mid_px[k*CB +: CB], window_ff[2][k*CB +: CB],
                                window_ff[5][k*CB +: CB], s1_px_ff[k*CB +: CB]);
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stage 2: per-channel gradients are held here; the maximum, the edge decision and the
   // level mapping are formed on the way into the output register.
   // ---------------------------------------------------------------------------------------
   logic                                s2_center_ff;
   logic [easc_pkg::POS_FIELD_BITS-1:0] s2_row_ff, s2_col_ff;
   logic [easc_pkg::GRAD_BITS-1:0]      s2_grad_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_free) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s2_center_ff <= s1_center_ff;
         s2_row_ff    <= s1_row_ff;
         s2_col_ff    <= s1_col_ff;
         for (int k = 0; k < 3; k++) begin
            s2_grad_ff[k] <= grad_in[k];
         end
      end
   end

   logic [easc_pkg::GRAD_BITS-1:0] max_a, max_g;
   logic                           edge_hit;
   logic [easc_pkg::COUNT_BITS-1:0] count_sel;
   easc_pkg::rsp_word_type         rsp_word_in, rsp_word_ff;

   always_comb begin
      max_a    = (s2_grad_ff[1] > s2_grad_ff[0]) ? s2_grad_ff[1] : s2_grad_ff[0];
      max_g    = (s2_grad_ff[2] > max_a) ? s2_grad_ff[2] : max_a;
      edge_hit = (s2_grad_ff[0] > edge_threshold_ff) || (s2_grad_ff[1] > edge_threshold_ff) ||
                 (s2_grad_ff[2] > edge_threshold_ff);

      // The highest level exceeded wins, whatever the order of the level registers.
      if (!edge_hit) begin
         count_sel = easc_pkg::COUNT_ONE;
      end else if (max_g > level_three_ff) begin
         count_sel = easc_pkg::COUNT_TWENTY_FIVE;
      end else if (max_g > level_two_ff) begin
         count_sel = easc_pkg::COUNT_SIXTEEN;
      end else if (max_g > level_one_ff) begin
         count_sel = easc_pkg::COUNT_NINE;
      end else if (max_g > level_quarter_ff) begin
         count_sel = easc_pkg::COUNT_FOUR;
      end else begin
         count_sel = easc_pkg::COUNT_ONE;
      end

      // Border positions report nothing but the default count of one.
      rsp_word_in              = '0;
      rsp_word_in.sample_count = easc_pkg::COUNT_ONE;
      if (s2_center_ff) begin
         rsp_word_in.center_valid = 1'b1;
         rsp_word_in.center_row   = s2_row_ff;
         rsp_word_in.center_col   = s2_col_ff;
         rsp_word_in.edge_found   = edge_hit;
         rsp_word_in.max_gradient = max_g;
         rsp_word_in.sample_count = count_sel;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Output register
   // ---------------------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_valid_ff && out_ready) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // ---------------------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------------------
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_word_ff.center_valid |->
         rsp_word_ff.sample_count == easc_pkg::COUNT_ONE && rsp_word_ff.max_gradient == '0)
      else $error("border result carries a gradient or a count other than one");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_word_ff.edge_found |->
         rsp_word_ff.sample_count == easc_pkg::COUNT_ONE)
      else $error("result without an edge asks for supersamples");

   assert property (@(posedge clock) disable iff (reset)
      fwd_valid_ff |-> s1_valid_ff)
      else $error("forwarded line data held with no word in the memory stage");

   assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> s2_valid_ff)
      else $error("word leaving the memory stage was lost before the gradient stage");

endmodule

// ===== tb/sv/tb_edge_adaptive_sample_count_unit.sv =====
// Self-checking testbench for the edge-adaptive sample count unit with a result scoreboard.
module tb_edge_adaptive_sample_count_unit;

   localparam int CLOCK_PERIOD   = 12;
   localparam int RESET_CYCLES   = 11;
   localparam int MAX_GAP        = 6;
   localparam int RANDOM_ITEMS   = 1300;
   localparam int DRAIN_PAD      = 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int REG_COUNT      = 7;
   localparam int MAX_REPORTS    = 10;
   localparam int CB             = easc_pkg::CHANNEL_BITS;

   // Index just past the last register; writes there must leave every register alone.
   localparam logic [2:0] SPARE_REG_INDEX = 3'd7;

   typedef enum {STYLE_NOISE, STYLE_SMOOTH, STYLE_BINARY} pixel_style_type;

   // Holds a private copy of the unit's configuration, line stores and window, works out the
   // result word for every accepted pixel word and checks the result words in order.
   class scoreboard_type;
      logic [easc_pkg::CFG_BITS-1:0]   regs [REG_COUNT];
      logic [easc_pkg::PIXEL_BITS-1:0] upper_line [easc_pkg::MAX_WIDTH];
      logic [easc_pkg::PIXEL_BITS-1:0] middle_line [easc_pkg::MAX_WIDTH];
      logic [easc_pkg::PIXEL_BITS-1:0] window [6];
      logic [easc_pkg::PIXEL_BITS-1:0] win_now [9];
      int                              col;
      int                              row;
      easc_pkg::rsp_word_type          expected_words [$];
      int                              errors;

      function new();
         regs[easc_pkg::REG_FRAME_WIDTH]    = 11'd600;
         regs[easc_pkg::REG_FRAME_HEIGHT]   = 11'd600;
         regs[easc_pkg::REG_EDGE_THRESHOLD] = 11'd127;
         regs[easc_pkg::REG_LEVEL_QUARTER]  = 11'd127;
         regs[easc_pkg::REG_LEVEL_ONE]      = 11'd255;
         regs[easc_pkg::REG_LEVEL_TWO]      = 11'd510;
         regs[easc_pkg::REG_LEVEL_THREE]    = 11'd765;
         for (int i = 0; i < easc_pkg::MAX_WIDTH; i++) begin
            upper_line[i]  = '0;
            middle_line[i] = '0;
         end
         for (int i = 0; i < 6; i++) window[i] = '0;
         col    = 0;
         row    = 0;
         errors = 0;
      endfunction

      static function int clamp_dim(int v, int hi);
         if (v < 3) return 3;
         if (v > hi) return hi;
         return v;
      endfunction

      function void set_reg(easc_pkg::reg_index_type idx, logic [easc_pkg::CFG_BITS-1:0] v);
         regs[idx] = v;
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      function void note_error(string msg);
         errors++;
         if (errors <= MAX_REPORTS) $display("mismatch: %s", msg);
      endfunction

      // Sobel magnitude of one channel over win_now (index col*3 + row).
      function int channel_gradient(int k);
         int t0, m0, b0, t1, b1, t2, m2, b2, gx, gy;
         t0 = int'(win_now[0][k*CB +: CB]);
         m0 = int'(win_now[1][k*CB +: CB]);
         b0 = int'(win_now[2][k*CB +: CB]);
         t1 = int'(win_now[3][k*CB +: CB]);
         b1 = int'(win_now[5][k*CB +: CB]);
         t2 = int'(win_now[6][k*CB +: CB]);
         m2 = int'(win_now[7][k*CB +: CB]);
         b2 = int'(win_now[8][k*CB +: CB]);
         gx = (t0 + 2 * t1 + t2) - (b0 + 2 * b1 + b2);
         gy = (t2 + 2 * m2 + b2) - (t0 + 2 * m0 + b0);
         return (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
      endfunction

      function void note_pixel(easc_pkg::req_word_type w);
         int                              cols, rows, r, c, g, peak;
         bit                              edge_hit;
         logic [easc_pkg::PIXEL_BITS-1:0] px, top, mid;
         easc_pkg::rsp_word_type          want;
         cols = clamp_dim(int'(regs[easc_pkg::REG_FRAME_WIDTH]), easc_pkg::MAX_WIDTH);
         rows = clamp_dim(int'(regs[easc_pkg::REG_FRAME_HEIGHT]), easc_pkg::MAX_HEIGHT);
         if (w.start_of_frame) begin
            col = 0;
            row = 0;
         end
         r = row;
         c = col;
         if (c >= cols) c = 0;
         if (r >= rows) r = 0;
         px  = {w.red, w.green, w.blue};
         top = upper_line[c];
         mid = middle_line[c];
         upper_line[c]  = mid;
         middle_line[c] = px;
         for (int i = 0; i < 6; i++) win_now[i] = window[i];
         win_now[6] = top;
         win_now[7] = mid;
         win_now[8] = px;

         want = '0;
         want.sample_count = easc_pkg::COUNT_ONE;
         if (r >= 2 && c >= 2) begin
            peak     = 0;
            edge_hit = 1'b0;
            for (int k = 0; k < 3; k++) begin
               g = channel_gradient(k);
               if (g > regs[easc_pkg::REG_EDGE_THRESHOLD]) edge_hit = 1'b1;
               if (g > peak) peak = g;
            end
            want.center_valid = 1'b1;
            want.center_row   = easc_pkg::POS_FIELD_BITS'(r - 1);
            want.center_col   = easc_pkg::POS_FIELD_BITS'(c - 1);
            want.edge_found   = edge_hit;
            want.max_gradient = easc_pkg::GRAD_BITS'(peak);
            if (edge_hit) begin
               if (peak > regs[easc_pkg::REG_LEVEL_THREE]) begin
                  want.sample_count = easc_pkg::COUNT_TWENTY_FIVE;
               end else if (peak > regs[easc_pkg::REG_LEVEL_TWO]) begin
                  want.sample_count = easc_pkg::COUNT_SIXTEEN;
               end else if (peak > regs[easc_pkg::REG_LEVEL_ONE]) begin
                  want.sample_count = easc_pkg::COUNT_NINE;
               end else if (peak > regs[easc_pkg::REG_LEVEL_QUARTER]) begin
                  want.sample_count = easc_pkg::COUNT_FOUR;
               end
            end
         end
         expected_words.insert(expected_words.size(), want);

         for (int i = 0; i < 6; i++) window[i] = win_now[i + 3];
         c++;
         if (c >= cols) begin
            c = 0;
            r++;
            if (r >= rows) r = 0;
         end
         col = c;
         row = r;
      endfunction

      function void check_result(easc_pkg::rsp_word_type got);
         easc_pkg::rsp_word_type want;
         bit                     bad;
         if (expected_words.size() == 0) begin
            note_error($sformatf("result word %h arrived with nothing outstanding", got));
            return;
         end
         want = expected_words.pop_front();
         bad  = 1'b0;
         if (got.center_valid !== want.center_valid) bad = 1'b1;
         if (got.center_row   !== want.center_row)   bad = 1'b1;
         if (got.center_col   !== want.center_col)   bad = 1'b1;
         if (got.edge_found   !== want.edge_found)   bad = 1'b1;
         if (got.max_gradient !== want.max_gradient) bad = 1'b1;
         if (got.sample_count !== want.sample_count) bad = 1'b1;
         if (bad) begin
            note_error($sformatf(
               {"valid/row/col/edge/grad/count got %0d/%0d/%0d/%0d/%0d/%0d",
                " want %0d/%0d/%0d/%0d/%0d/%0d"},
               got.center_valid, got.center_row, got.center_col, got.edge_found,
               got.max_gradient, got.sample_count, want.center_valid, want.center_row,
               want.center_col, want.edge_found, want.max_gradient, want.sample_count));
         end
      endfunction
   endclass

   // Every input is given a known value from time zero; all later changes are nonblocking
   // assignments made at a rising edge.
   logic                                clock       = 1'b0;
   logic                                reset       = 1'b1;
   logic                                req_valid   = 1'b0;
   logic                                req_stall;
   easc_pkg::req_word_type              req_word    = '0;
   logic                                rsp_valid;
   logic                                rsp_stall   = 1'b0;
   easc_pkg::rsp_word_type              rsp_word;
   logic                                csr_psel    = 1'b0;
   logic                                csr_penable = 1'b0;
   logic                                csr_pwrite  = 1'b0;
   logic [easc_pkg::CSR_ADDR_BITS-1:0]  csr_paddr   = '0;
   logic [easc_pkg::CSR_DATA_BITS-1:0]  csr_pwdata  = '0;
   logic [easc_pkg::CSR_DATA_BITS-1:0]  csr_prdata;
   logic                                csr_pready;

   scoreboard_type           sb;
   bit                       steady = 1'b0;   // when set, neither side idles
   int                       quiet_cycles = 0;

   edge_adaptive_sample_count_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Both sides draw a fresh idle count for every word, unless a steady stretch is running.
   function automatic int draw_gap();
      return steady ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   function automatic logic [CB-1:0] make_channel(pixel_style_type style, int base);
      case (style)
         STYLE_SMOOTH: return CB'(base + $urandom_range(0, 16));
         STYLE_BINARY: return $urandom_range(0, 1) ? {CB{1'b1}} : {CB{1'b0}};
         default:      return CB'($urandom_range(0, 255));
      endcase
   endfunction

   // Monitors. Sampling at the rising edge sees the values that the unit itself sees, since all
   // inputs change through nonblocking assignments. The input word is noted before the result
   // word is checked, although a result must first pass the pipeline registers.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) sb.note_pixel(req_word);
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_word);
   end

   // The watchdog counts cycles in which no word moves on either channel. Idle gaps are short,
   // so a long quiet spell means the unit has hung or lost a result.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Result sink: stalls for a random number of cycles, then accepts one word. Raising and
   // lowering the stall always fall on different edges.
   initial begin : result_sink
      int gap;
      while (reset) @(posedge clock);
      forever begin
         gap = draw_gap();
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // Offers one pixel word after a random idle gap and returns at the edge that accepts it.
   // With no gap, valid simply stays high and the next word replaces the accepted one.
   task automatic send_pixel(input easc_pkg::req_word_type w);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // An APB write: setup cycle, access cycle, then an idle cycle so that back-to-back
   // transfers never assign psel twice in one step.
   task automatic csr_write(input logic [easc_pkg::CSR_ADDR_BITS-1:0] addr,
                            input logic [easc_pkg::CSR_DATA_BITS-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // An APB read; the read data is taken in the middle of the access cycle.
   task automatic csr_read(input logic [easc_pkg::CSR_ADDR_BITS-1:0] addr,
                           output logic [easc_pkg::CSR_DATA_BITS-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= addr;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      data = csr_prdata;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Writes one register with random junk above its eleven bits, which the unit must drop.
   task automatic write_reg(input easc_pkg::reg_index_type idx,
                            input logic [easc_pkg::CFG_BITS-1:0] value);
      logic [easc_pkg::CSR_DATA_BITS-1:0] data;
      data = $urandom();
      data[easc_pkg::CFG_BITS-1:0] = value;
      csr_write({idx, 2'b00}, data);
      sb.set_reg(idx, value);
   endtask

   // Reads every register back and compares it with the scoreboard's copy.
   task automatic check_regs();
      easc_pkg::reg_index_type            idx;
      logic [easc_pkg::CSR_DATA_BITS-1:0] got;
      idx = idx.first();
      repeat (idx.num()) begin
         csr_read({idx, 2'b00}, got);
         if (got !== easc_pkg::CSR_DATA_BITS'(sb.regs[idx])) begin
            sb.note_error($sformatf("register %s reads %0h, wanted %0h",
                                    idx.name(), got, sb.regs[idx]));
         end
         idx = idx.next();
      end
   endtask

   // Stops the sender, waits for every outstanding result and then the drain pad, so that
   // the pipeline is empty before any register changes.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_PAD) @(posedge clock);
   endtask

   // Sends whole frames in raster order. The very first pixel always carries start of frame,
   // so that a new frame width never lets the unit read a line store entry it has not written.
   // Later frames either restart explicitly or rely on the counters wrapping. A noisy run adds
   // stray frame restarts and may stop part way through a frame.
   task automatic run_frames(input int cols, input int rows, input int frames,
                             input pixel_style_type style, input bit noisy, inout int sent);
      easc_pkg::req_word_type w;
      int                     base;
      base = $urandom_range(0, 239);
      for (int f = 0; f < frames; f++) begin
         for (int r = 0; r < rows; r++) begin
            for (int c = 0; c < cols; c++) begin
               if (noisy && $urandom_range(0, 199) == 0) return;
               w.start_of_frame = (r == 0 && c == 0 && (f == 0 || $urandom_range(0, 1) == 1)) ||
                                  (noisy && $urandom_range(0, 49) == 0);
               w.red   = make_channel(style, base);
               w.green = make_channel(style, base);
               w.blue  = make_channel(style, base);
               send_pixel(w);
               sent++;
            end
         end
      end
   endtask

   initial begin : stimulus
      easc_pkg::req_word_type   w;
      int unsigned              v;
      int                       phase;
      int                       random_sent;
      int                       wv, hv;
      int                       lv [4];
      pixel_style_type          style;
      bit                       noisy;

      sb = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Registers must come out of reset with their documented values, and a write beyond the
      // last register must change none of them.
      check_regs();
      csr_write({SPARE_REG_INDEX, 2'b00}, {easc_pkg::CSR_DATA_BITS{1'b1}});
      check_regs();

      // Directed part. Width and height below three are clamped, giving 3x3 frames with one
      // interior centre each. The first frame has the strongest gradient the Sobel kernel can
      // reach (1530 in red and green, flat blue). The second follows on by row wrap alone and
      // gives 256, just above the threshold of 254; the third gives exactly 254, which is not
      // an edge and so yields a count of one.
      write_reg(easc_pkg::REG_FRAME_WIDTH, 11'd1);
      write_reg(easc_pkg::REG_FRAME_HEIGHT, 11'd2);
      write_reg(easc_pkg::REG_EDGE_THRESHOLD, 11'd254);
      check_regs();
      for (int f = 0; f < 3; f++) begin
         for (int i = 0; i < 9; i++) begin
            case (f)
               0:       v = (i == 1 || i == 2 || i == 5) ? 255 : 0;
               1:       v = (i == 1) ? 128 : 0;
               default: v = (i == 1) ? 127 : 0;
            endcase
            w.start_of_frame = (i == 0) && (f != 1);
            w.red   = CB'(v);
            w.green = {CB{1'b1}} - CB'(v);
            w.blue  = (f == 0) ? {CB{1'b1}} : {CB{1'b0}};
            send_pixel(w);
         end
      end

      // Random part: each phase drains the unit, writes a fresh configuration, checks it by
      // reading it back and then streams a few small frames. One phase writes the top of the
      // width field, which clamps to the largest width, and sends one full row, so that the
      // column counter reaches its last column and wraps into the next row.
      phase       = 0;
      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         settle();
         steady = ($urandom_range(0, 3) == 0);
         if (phase == 2) begin
            write_reg(easc_pkg::REG_FRAME_WIDTH, 11'd2047);
            write_reg(easc_pkg::REG_FRAME_HEIGHT, 11'd3);
            check_regs();
            run_frames(easc_pkg::MAX_WIDTH, 1, 1, STYLE_NOISE, 1'b0, random_sent);
         end else begin
            wv = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 9);
            hv = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
            write_reg(easc_pkg::REG_FRAME_WIDTH, easc_pkg::CFG_BITS'(wv));
            write_reg(easc_pkg::REG_FRAME_HEIGHT, easc_pkg::CFG_BITS'(hv));
            case ($urandom_range(0, 7))
               0:       write_reg(easc_pkg::REG_EDGE_THRESHOLD, 11'd0);
               1:       write_reg(easc_pkg::REG_EDGE_THRESHOLD, 11'd2040);
               2:       write_reg(easc_pkg::REG_EDGE_THRESHOLD, 11'd2047);
               default: write_reg(easc_pkg::REG_EDGE_THRESHOLD,
                                  easc_pkg::CFG_BITS'($urandom_range(0, 600)));
            endcase
            // Levels are mostly ordered; sometimes they are shuffled or pinned to the extremes,
            // where the highest level exceeded must still win.
            case ($urandom_range(0, 5))
               0: for (int i = 0; i < 4; i++) lv[i] = $urandom_range(0, 2047);
               1: for (int i = 0; i < 4; i++) lv[i] = $urandom_range(0, 1) ? 2040 : 0;
               default: begin
                  for (int i = 0; i < 4; i++) lv[i] = $urandom_range(0, 1600);
                  lv.sort();
               end
            endcase
            write_reg(easc_pkg::REG_LEVEL_QUARTER, easc_pkg::CFG_BITS'(lv[0]));
            write_reg(easc_pkg::REG_LEVEL_ONE, easc_pkg::CFG_BITS'(lv[1]));
            write_reg(easc_pkg::REG_LEVEL_TWO, easc_pkg::CFG_BITS'(lv[2]));
            write_reg(easc_pkg::REG_LEVEL_THREE, easc_pkg::CFG_BITS'(lv[3]));
            check_regs();
            style = pixel_style_type'($urandom_range(0, 2));
            noisy = ($urandom_range(0, 4) == 0);
            run_frames(scoreboard_type::clamp_dim(wv, easc_pkg::MAX_WIDTH),
                       scoreboard_type::clamp_dim(hv, easc_pkg::MAX_HEIGHT),
                       $urandom_range(1, 3), style, noisy, random_sent);
         end
         phase++;
      end

      // Let the last results arrive; anything extra during the pad counts as a mismatch.
      settle();
      if (sb.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
